// ===== hw/rtl/srtf_tick_scheduler_top_macros.svh =====
// Assertion helpers for the checker file.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef SRTF_TICK_SCHEDULER_TOP_MACROS_SVH
`define SRTF_TICK_SCHEDULER_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SRTF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SRTF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/srtf_pkg.sv =====
package srtf_pkg;

  localparam int MAX_TASKS = 16;
  localparam int TIME_BITS = 16;

  localparam int IDX_W  = $clog2(MAX_TASKS);
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);
  localparam int ACT_W  = 5;
  localparam int SLOT_W = 4;
  localparam int ARR_W  = 16;
  localparam int BUR_W  = 12;
  localparam int F16_W  = 16;
  localparam int SUM_W  = 20;
  localparam int FCNT_W = 5;
  localparam int CMP_W  = (TIME_BITS > ARR_W) ? TIME_BITS : ARR_W;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } sched_state_e;

  typedef struct packed {
    logic [ARR_W-1:0] arr;
    logic [BUR_W-1:0] bur;
    logic [BUR_W-1:0] rem;
  } entry_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    entry_t           wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
  } tbl_req_t;

  typedef struct packed {
    logic              ran_valid;
    logic [SLOT_W-1:0] ran_index;
    logic              finished;
    logic [F16_W-1:0]  completion_time;
    logic [F16_W-1:0]  turnaround;
    logic [F16_W-1:0]  waiting;
    logic [SUM_W-1:0]  sum_turnaround;
    logic [SUM_W-1:0]  sum_waiting;
    logic              all_done;
    logic [F16_W-1:0]  time_now;
  } result_t;

endpackage

// ===== hw/rtl/srtf_table.sv =====
module srtf_table
  import srtf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  tbl_req_t req_i,
  output entry_t   rd_data_o
);

  entry_t               mem_q [MAX_TASKS];
  logic [MAX_TASKS-1:0] valid_q;
  entry_t               rd_q;
  logic                 rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_idx] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q <= mem_q[req_i.rd_idx];
    end
  end

  // Valid bits stand in for the zero reset of the remaining-time column.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        valid_q[req_i.wr_idx] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[req_i.rd_idx];
      end
    end
  end

  always_comb begin
    rd_data_o     = rd_q;
    rd_data_o.rem = rd_valid_q ? rd_q.rem : '0;
  end

endmodule

// ===== hw/rtl/srtf_sched.sv =====
module srtf_sched
  import srtf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  op_e               op_i,
  input  logic [SLOT_W-1:0] slot_i,
  input  logic [ARR_W-1:0]  arr_i,
  input  logic [BUR_W-1:0]  bur_i,
  input  logic [CNT_W-1:0]  active_i,
  input  logic              slot_free_i,
  input  entry_t            rd_data_i,
  output tbl_req_t          tbl_req_o,
  output logic              busy_o,
  output logic              res_valid_o,
  output result_t           res_o
);

  localparam logic [TIME_BITS-1:0] TimeMax = '1;
  localparam logic [SUM_W-1:0]     SumMax  = '1;
  localparam logic [FCNT_W-1:0]    FcntMax = '1;

  sched_state_e state_q, state_d;

  op_e              op_q;
  logic [CNT_W-1:0] cnt_q;
  logic             rd_pend_q;
  logic             found_q;
  logic [IDX_W-1:0] best_idx_q;
  logic [ARR_W-1:0] best_arr_q;
  logic [BUR_W-1:0] best_bur_q;
  logic [BUR_W-1:0] best_rem_q;

  logic [TIME_BITS-1:0] time_q;
  logic [FCNT_W-1:0]    fcnt_q;
  logic [SUM_W-1:0]     sum_tat_q;
  logic [SUM_W-1:0]     sum_wt_q;

  logic                 load_ok;
  logic                 cand;
  logic                 emit;
  logic                 tick;
  logic                 fin;
  logic [TIME_BITS-1:0] time_nx;
  logic [CMP_W-1:0]     t_diff;
  logic [F16_W-1:0]     tat;
  logic [F16_W-1:0]     wt;
  logic [SUM_W:0]       sum_tat_raw;
  logic [SUM_W:0]       sum_wt_raw;
  logic [SUM_W-1:0]     sum_tat_nx;
  logic [SUM_W-1:0]     sum_wt_nx;
  logic [FCNT_W-1:0]    fcnt_nx;

  assign load_ok = (int'(slot_i) < MAX_TASKS);

  // Candidate test on the entry read last cycle.
  assign cand = rd_pend_q && (rd_data_i.rem != '0)
                && (CMP_W'(rd_data_i.arr) <= CMP_W'(time_q))
                && (!found_q || (rd_data_i.rem < best_rem_q));

  assign emit = (state_q == S_EMIT) && slot_free_i;
  assign tick = (op_q == OP_TICK);
  assign fin  = tick && found_q && (best_rem_q == BUR_W'(1));

  // Completion arithmetic for the served entry.
  always_comb begin
    time_nx     = (time_q == TimeMax) ? time_q : time_q + TIME_BITS'(1);
    t_diff      = CMP_W'(time_nx) - CMP_W'(best_arr_q);
    tat         = (t_diff > CMP_W'({F16_W{1'b1}})) ? '1 : F16_W'(t_diff);
    wt          = (tat > F16_W'(best_bur_q)) ? tat - F16_W'(best_bur_q) : '0;
    sum_tat_raw = {1'b0, sum_tat_q} + (SUM_W + 1)'(tat);
    sum_wt_raw  = {1'b0, sum_wt_q} + (SUM_W + 1)'(wt);
    sum_tat_nx  = sum_tat_raw[SUM_W] ? SumMax : sum_tat_raw[SUM_W-1:0];
    sum_wt_nx   = sum_wt_raw[SUM_W] ? SumMax : sum_wt_raw[SUM_W-1:0];
    fcnt_nx     = (fcnt_q == FcntMax) ? fcnt_q : fcnt_q + FCNT_W'(1);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = (op_i == OP_TICK) ? S_SCAN : S_EMIT;
      end
      S_SCAN: begin
        if (cnt_q == active_i) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    tbl_req_o   = '0;
    busy_o      = (state_q != S_IDLE);
    res_valid_o = 1'b0;
    res_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        tbl_req_o.wr_en   = start_i && (op_i == OP_LOAD) && load_ok;
        tbl_req_o.wr_idx  = IDX_W'(slot_i);
        tbl_req_o.wr_data = '{arr: arr_i, bur: bur_i, rem: bur_i};
      end
      S_SCAN: begin
        tbl_req_o.rd_en  = (cnt_q < active_i);
        tbl_req_o.rd_idx = cnt_q[IDX_W-1:0];
      end
      S_EMIT: begin
        tbl_req_o.wr_en   = emit && tick && found_q;
        tbl_req_o.wr_idx  = best_idx_q;
        tbl_req_o.wr_data = '{arr: best_arr_q, bur: best_bur_q,
                              rem: best_rem_q - BUR_W'(1)};
        res_valid_o           = emit;
        res_o.ran_valid       = tick && found_q;
        res_o.ran_index       = (tick && found_q) ? SLOT_W'(best_idx_q) : '0;
        res_o.finished        = fin;
        res_o.completion_time = fin ? F16_W'(time_nx) : '0;
        res_o.turnaround      = fin ? tat : '0;
        res_o.waiting         = fin ? wt : '0;
        res_o.sum_turnaround  = fin ? sum_tat_nx : sum_tat_q;
        res_o.sum_waiting     = fin ? sum_wt_nx : sum_wt_q;
        res_o.all_done        = int'(fin ? fcnt_nx : fcnt_q) >= int'(active_i);
        res_o.time_now        = tick ? F16_W'(time_nx) : F16_W'(time_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      op_q      <= OP_LOAD;
      cnt_q     <= '0;
      rd_pend_q <= 1'b0;
      found_q   <= 1'b0;
      time_q    <= '0;
      fcnt_q    <= '0;
      sum_tat_q <= '0;
      sum_wt_q  <= '0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= tbl_req_o.rd_en;
      if (start_i && (state_q == S_IDLE)) begin
        op_q    <= op_i;
        cnt_q   <= '0;
        found_q <= 1'b0;
      end
      if ((state_q == S_SCAN) && (cnt_q < active_i)) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (cand) begin
        found_q <= 1'b1;
      end
      if (emit && tick) begin
        time_q <= time_nx;
      end
      if (emit && fin) begin
        fcnt_q    <= fcnt_nx;
        sum_tat_q <= sum_tat_nx;
        sum_wt_q  <= sum_wt_nx;
      end
    end
  end

  // Hold the best entry seen so far in the scan.
  always_ff @(posedge clk_i) begin
    if (cand) begin
      best_idx_q <= cnt_q[IDX_W-1:0] - IDX_W'(1);
      best_arr_q <= rd_data_i.arr;
      best_bur_q <= rd_data_i.bur;
      best_rem_q <= rd_data_i.rem;
    end
  end

endmodule

// ===== hw/rtl/srtf_tick_scheduler_top.sv =====
// Shortest-remaining-time-first tick scheduler. Each input item is either a
// load (operation 0), which writes one table slot's arrival time and burst
// length, or a tick (operation 1), which serves the ready entry with the least
// remaining time (lowest slot on a tie) and advances time by one, saturating.
// Every item yields exactly one result item; finishing entries report
// completion, turnaround and waiting times and fold them into running sums.
// A load keeps the block busy until its result is emitted. A tick scans the
// first N entries, N being active_count capped at 16: the table sits in one
// synchronous memory with a single read port, the scan reads one entry per
// cycle, and the served entry is written back as its result is emitted.
// Results sit in an output register, so the next item is taken while one
// result still waits downstream. active_count is written through the config
// channel (always ready) and must only change while no item is in flight.
// The table needs no clearing pass after reset.
module srtf_tick_scheduler_top
  import srtf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // config channel
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [ACT_W-1:0]  cfg_active_count_i,
  // input item channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              operation_i,
  input  logic [SLOT_W-1:0] entry_index_i,
  input  logic [ARR_W-1:0]  arrival_time_i,
  input  logic [BUR_W-1:0]  burst_length_i,
  // result item channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              ran_valid_o,
  output logic [SLOT_W-1:0] ran_index_o,
  output logic              finished_o,
  output logic [F16_W-1:0]  completion_time_o,
  output logic [F16_W-1:0]  turnaround_o,
  output logic [F16_W-1:0]  waiting_o,
  output logic [SUM_W-1:0]  sum_turnaround_o,
  output logic [SUM_W-1:0]  sum_waiting_o,
  output logic              all_done_o,
  output logic [F16_W-1:0]  time_now_o
);

  logic [ACT_W-1:0] active_q;
  logic [CNT_W-1:0] active_eff;

  logic     busy;
  logic     in_accept;
  logic     slot_free;
  logic     res_valid;
  result_t  res;
  result_t  out_q;
  logic     out_valid_q;
  tbl_req_t tbl_req;
  entry_t   rd_data;

  // Config register: always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      active_q <= cfg_active_count_i;
    end
  end

  // Clamp active_count to the table depth.
  assign active_eff = (int'(active_q) > MAX_TASKS) ? CNT_W'(MAX_TASKS)
                                                   : CNT_W'(active_q);

  assign in_stall_o = busy;
  assign in_accept  = in_valid_i && !busy;

  // Output register frees up when empty or when its item leaves this edge.
  assign slot_free = !out_valid_q || !out_stall_i;

  srtf_table u_table (
    .clk_i,
    .rst_ni,
    .req_i     (tbl_req),
    .rd_data_o (rd_data)
  );

  srtf_sched u_sched (
    .clk_i,
    .rst_ni,
    .start_i     (in_accept),
    .op_i        (op_e'(operation_i)),
    .slot_i      (entry_index_i),
    .arr_i       (arrival_time_i),
    .bur_i       (burst_length_i),
    .active_i    (active_eff),
    .slot_free_i (slot_free),
    .rd_data_i   (rd_data),
    .tbl_req_o   (tbl_req),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Hold the result until downstream takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign ran_valid_o       = out_q.ran_valid;
  assign ran_index_o       = out_q.ran_index;
  assign finished_o        = out_q.finished;
  assign completion_time_o = out_q.completion_time;
  assign turnaround_o      = out_q.turnaround;
  assign waiting_o         = out_q.waiting;
  assign sum_turnaround_o  = out_q.sum_turnaround;
  assign sum_waiting_o     = out_q.sum_waiting;
  assign all_done_o        = out_q.all_done;
  assign time_now_o        = out_q.time_now;

endmodule

// ===== hw/rtl/srtf_checker.sv =====
`include "srtf_tick_scheduler_top_macros.svh"

module srtf_checker
  import srtf_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic              ran_valid_o,
  input logic              finished_o,
  input logic [F16_W-1:0]  completion_time_o,
  input logic [SUM_W-1:0]  sum_turnaround_o,
  input logic [F16_W-1:0]  time_now_o
);

  // A finish only comes with a served entry.
  `SRTF_ASSERT_NOW(a_fin_served, out_valid_o && finished_o, ran_valid_o,
                   "finish without service")

  // The completion time is the time reported after that tick.
  `SRTF_ASSERT_NOW(a_fin_time, out_valid_o && finished_o,
                   completion_time_o == time_now_o,
                   "completion time differs from time_now")

  // An accepted item keeps the block busy in the cycle after acceptance.
  `SRTF_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o,
                    "input not stalled after accept")

  // A stalled result holds.
  `SRTF_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
                    out_valid_o && $stable(time_now_o) && $stable(sum_turnaround_o),
                    "stalled result changed")

endmodule

bind srtf_tick_scheduler_top srtf_checker u_srtf_checker (.*);

// ===== dv/tb_srtf_tick_scheduler_top.sv =====
module tb_srtf_tick_scheduler_top;
  timeunit 1ns;
  timeprecision 1ps;

  import srtf_pkg::*;

  // Handshake-free stretch after which the run is declared hung. The slowest
  // legal gap is the receiver's long hold-off plus one full tick scan.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned LONG_HOLD      = 120;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned END_CYCLES     = 40;
  localparam int unsigned WORKLOAD_ITEMS = 110;
  localparam logic [SUM_W:0] SUM_MAX     = (1 << SUM_W) - 1;

  // One row of the directed table: either an active_count write or an item.
  // Rows with known_result set carry the result typed in by hand.
  typedef struct packed {
    logic              is_cfg;
    logic [ACT_W-1:0]  cfg_val;
    op_e               op;
    logic [SLOT_W-1:0] slot;
    logic [ARR_W-1:0]  arr;
    logic [BUR_W-1:0]  bur;
    logic              known_result;
    result_t           want;
  } dir_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [ACT_W-1:0]  cfg_active_count_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              operation_i;
  logic [SLOT_W-1:0] entry_index_i;
  logic [ARR_W-1:0]  arrival_time_i;
  logic [BUR_W-1:0]  burst_length_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic              ran_valid_o;
  logic [SLOT_W-1:0] ran_index_o;
  logic              finished_o;
  logic [F16_W-1:0]  completion_time_o;
  logic [F16_W-1:0]  turnaround_o;
  logic [F16_W-1:0]  waiting_o;
  logic [SUM_W-1:0]  sum_turnaround_o;
  logic [SUM_W-1:0]  sum_waiting_o;
  logic              all_done_o;
  logic [F16_W-1:0]  time_now_o;

  srtf_tick_scheduler_top uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_active_count_i(cfg_active_count_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .operation_i       (operation_i),
    .entry_index_i     (entry_index_i),
    .arrival_time_i    (arrival_time_i),
    .burst_length_i    (burst_length_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .ran_valid_o       (ran_valid_o),
    .ran_index_o       (ran_index_o),
    .finished_o        (finished_o),
    .completion_time_o (completion_time_o),
    .turnaround_o      (turnaround_o),
    .waiting_o         (waiting_o),
    .sum_turnaround_o  (sum_turnaround_o),
    .sum_waiting_o     (sum_waiting_o),
    .all_done_o        (all_done_o),
    .time_now_o        (time_now_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Scheduler shadow: its own copy of the task table, clock and running sums.
  // ---------------------------------------------------------------------------
  logic [ARR_W-1:0]     arr_tbl [MAX_TASKS];
  logic [BUR_W-1:0]     bur_tbl [MAX_TASKS];
  logic [BUR_W-1:0]     rem_tbl [MAX_TASKS];
  logic [TIME_BITS-1:0] now_time;
  logic [FCNT_W-1:0]    fin_cnt;
  logic [SUM_W-1:0]     tat_total;
  logic [SUM_W-1:0]     wait_total;
  logic [ACT_W-1:0]     act_cnt;

  result_t pending_results[$];

  int unsigned src_gap_max;
  int unsigned sink_gap_max;
  bit          hold_request;
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned cfg_writes;
  int unsigned served_seen;
  int unsigned completions_seen;
  int unsigned idle_cycles;

  // Apply one item to the shadow table and return the result it must cause.
  function automatic result_t schedule_item(op_e op, logic [SLOT_W-1:0] slot,
                                            logic [ARR_W-1:0] arr,
                                            logic [BUR_W-1:0] bur);
    result_t     r;
    int          n;
    int          i;
    int          best;
    bit          found;
    logic [BUR_W-1:0] best_rem;
    int unsigned tat;
    int unsigned wt;
    logic [SUM_W:0] sum;
    r = '0;
    // Active counts above the table size scan the whole table.
    n = (act_cnt > MAX_TASKS) ? MAX_TASKS : int'(act_cnt);
    if (op == OP_LOAD) begin
      arr_tbl[slot] = arr;
      bur_tbl[slot] = bur;
      rem_tbl[slot] = bur;
    end else begin
      found    = 1'b0;
      best     = 0;
      best_rem = '0;
      // Strict less-than keeps the lowest index on a tie.
      for (i = 0; i < n; i++) begin
        if (arr_tbl[i] <= now_time && rem_tbl[i] != '0 &&
            (!found || rem_tbl[i] < best_rem)) begin
          found    = 1'b1;
          best     = i;
          best_rem = rem_tbl[i];
        end
      end
      if (now_time != '1) now_time++;
      if (found) begin
        r.ran_valid    = 1'b1;
        r.ran_index    = SLOT_W'(best);
        rem_tbl[best]  = best_rem - 1'b1;
        if (rem_tbl[best] == '0) begin
          tat = int'(now_time) - int'(arr_tbl[best]);
          if (tat > 32'hFFFF) tat = 32'hFFFF;
          wt  = (tat > int'(bur_tbl[best])) ? tat - int'(bur_tbl[best]) : 0;
          r.finished        = 1'b1;
          r.completion_time = F16_W'(now_time);
          r.turnaround      = F16_W'(tat);
          r.waiting         = F16_W'(wt);
          if (fin_cnt != '1) fin_cnt++;
          sum        = {1'b0, tat_total} + (SUM_W + 1)'(tat);
          tat_total  = (sum > SUM_MAX) ? '1 : sum[SUM_W-1:0];
          sum        = {1'b0, wait_total} + (SUM_W + 1)'(wt);
          wait_total = (sum > SUM_MAX) ? '1 : sum[SUM_W-1:0];
        end
      end
    end
    r.sum_turnaround = tat_total;
    r.sum_waiting    = wait_total;
    r.all_done       = (int'(fin_cnt) >= n);
    r.time_now       = F16_W'(now_time);
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table helpers
  // ---------------------------------------------------------------------------
  function automatic dir_row_t cfg_row(logic [ACT_W-1:0] v);
    dir_row_t r;
    r         = '0;
    r.is_cfg  = 1'b1;
    r.cfg_val = v;
    return r;
  endfunction

  function automatic dir_row_t item_row(op_e op, logic [SLOT_W-1:0] slot,
                                        logic [ARR_W-1:0] arr, logic [BUR_W-1:0] bur);
    dir_row_t r;
    r      = '0;
    r.op   = op;
    r.slot = slot;
    r.arr  = arr;
    r.bur  = bur;
    return r;
  endfunction

  // Items with active_count at zero: nothing served, all_done set, only time moves.
  function automatic dir_row_t known_row(op_e op, logic [SLOT_W-1:0] slot,
                                         logic [ARR_W-1:0] arr, logic [BUR_W-1:0] bur,
                                         logic [F16_W-1:0] t);
    dir_row_t r;
    r                = item_row(op, slot, arr, bur);
    r.known_result   = 1'b1;
    r.want.all_done  = 1'b1;
    r.want.time_now  = t;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one item after a random gap; record its result once it is taken.
  // Valid is only lowered when a gap is drawn, so back-to-back items keep
  // valid high without a second assignment in the same step.
  task automatic send_item(op_e op, logic [SLOT_W-1:0] slot, logic [ARR_W-1:0] arr,
                           logic [BUR_W-1:0] bur, bit known_result, result_t want);
    int unsigned gap;
    result_t     shadow;
    gap = (src_gap_max != 0) ? $urandom_range(0, src_gap_max) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    entry_index_i  <= slot;
    arrival_time_i <= arr;
    burst_length_i <= bur;
    do @(posedge clk_i); while (in_stall_o);
    shadow = schedule_item(op, slot, arr, bur);
    pending_results.push_back(known_result ? want : shadow);
    items_sent++;
  endtask

  // Hold the input side until every outstanding result has been collected.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // active_count only changes while the block holds no item.
  task automatic write_active_count(logic [ACT_W-1:0] v);
    drain_results();
    cfg_valid_i        <= 1'b1;
    cfg_active_count_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    act_cnt = v;
    cfg_writes++;
  endtask

  // Load a small batch of tasks arriving around the current time, then tick
  // long enough to finish most of them. A few loads carry far-off arrivals or
  // long bursts, and ticks carry random payload bits that must be ignored.
  task automatic run_workload(int unsigned n_items);
    int unsigned      start;
    int unsigned      batch;
    int unsigned      k;
    int               n;
    logic [SLOT_W-1:0] slot;
    logic [ARR_W-1:0] arr;
    logic [BUR_W-1:0] bur;
    start = items_sent;
    while (items_sent - start < n_items) begin
      n     = (act_cnt > MAX_TASKS) ? MAX_TASKS : int'(act_cnt);
      batch = $urandom_range(1, 5);
      for (k = 0; k < batch; k++) begin
        if (n != 0 && $urandom_range(0, 3) != 0) slot = SLOT_W'($urandom_range(0, n - 1));
        else slot = SLOT_W'($urandom);
        if ($urandom_range(0, 7) == 0) arr = ARR_W'($urandom);
        else arr = ARR_W'(now_time) + ARR_W'($urandom_range(0, 6));
        if ($urandom_range(0, 9) == 0) bur = BUR_W'($urandom);
        else bur = BUR_W'($urandom_range(1, 12));
        send_item(OP_LOAD, slot, arr, bur, 1'b0, '0);
      end
      batch = $urandom_range(1, 30);
      for (k = 0; k < batch; k++)
        send_item(OP_TICK, SLOT_W'($urandom), ARR_W'($urandom), BUR_W'($urandom), 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result sink: random stall per item, one long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    result_t     want;
    int unsigned hold;
    @(posedge rst_ni);
    forever begin
      if (hold_request) begin
        hold         = LONG_HOLD;
        hold_request = 1'b0;
      end else begin
        hold = (sink_gap_max != 0) ? $urandom_range(0, sink_gap_max) : 0;
      end
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
      if (ran_valid_o === 1'b1) served_seen++;
      if (finished_o === 1'b1) completions_seen++;
      if (pending_results.size() == 0) begin
        $error("result item arrived with nothing expected");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("ran_valid",       32'(want.ran_valid),       32'(ran_valid_o));
        check_field("ran_index",       32'(want.ran_index),       32'(ran_index_o));
        check_field("finished",        32'(want.finished),        32'(finished_o));
        check_field("completion_time", 32'(want.completion_time), 32'(completion_time_o));
        check_field("turnaround",      32'(want.turnaround),      32'(turnaround_o));
        check_field("waiting",         32'(want.waiting),         32'(waiting_o));
        check_field("sum_turnaround",  32'(want.sum_turnaround),  32'(sum_turnaround_o));
        check_field("sum_waiting",     32'(want.sum_waiting),     32'(sum_waiting_o));
        check_field("all_done",        32'(want.all_done),        32'(all_done_o));
        check_field("time_now",        32'(want.time_now),        32'(time_now_o));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: count cycles without any handshake on any channel.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               idle_cycles, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    dir_row_t    dir_rows[$];
    dir_row_t    row;
    int unsigned k;
    logic [ACT_W-1:0] settings[7];
    int unsigned src_modes[7];
    int unsigned sink_modes[7];

    // Drive every input known from time zero.
    rst_ni             = 1'b0;
    cfg_valid_i        = 1'b0;
    cfg_active_count_i = '0;
    in_valid_i         = 1'b0;
    operation_i        = OP_LOAD;
    entry_index_i      = '0;
    arrival_time_i     = '0;
    burst_length_i     = '0;
    out_stall_i        = 1'b0;
    hold_request       = 1'b0;
    src_gap_max        = 8;
    sink_gap_max       = 8;
    mismatches         = 0;
    items_sent         = 0;
    cfg_writes         = 0;
    served_seen        = 0;
    completions_seen   = 0;
    idle_cycles        = 0;

    // Shadow state as the block leaves reset.
    foreach (arr_tbl[i]) begin
      arr_tbl[i] = '0;
      bur_tbl[i] = '0;
      rem_tbl[i] = '0;
    end
    now_time   = '0;
    fin_cnt    = '0;
    tat_total  = '0;
    wait_total = '0;
    act_cnt    = '0;

    // Directed table. Slots 0..2 and 15 are the only ones written here, and
    // active_count never reaches past slot 2 until the whole table is loaded.
    // Idle tick straight out of reset: no entries take part, only time moves.
    dir_rows.push_back(known_row(OP_TICK, 4'd0, 16'd0, 12'd0, 16'd1));
    dir_rows.push_back(known_row(OP_LOAD, 4'd0, 16'd0, 12'd3, 16'd1));
    dir_rows.push_back(known_row(OP_LOAD, 4'd1, 16'd2, 12'd1, 16'd1));
    // Zero burst: the entry exists but is never served.
    dir_rows.push_back(known_row(OP_LOAD, 4'd2, 16'd0, 12'd0, 16'd1));
    dir_rows.push_back(cfg_row(5'd3));
    dir_rows.push_back(item_row(OP_TICK, 4'd0, 16'd0, 12'd0));
    // Shorter job arrives and preempts slot 0, finishing on its first tick.
    dir_rows.push_back(item_row(OP_TICK, 4'd0, 16'd0, 12'd0));
    dir_rows.push_back(item_row(OP_TICK, 4'd0, 16'd0, 12'd0));
    dir_rows.push_back(item_row(OP_TICK, 4'd0, 16'd0, 12'd0));
    // Nothing left to run: idle tick.
    dir_rows.push_back(item_row(OP_TICK, 4'hF, 16'hFFFF, 12'hFFF));
    // Reload the zero-burst slot with an arrival that never comes.
    dir_rows.push_back(item_row(OP_LOAD, 4'd2, 16'hFFFF, 12'hFFF));
    dir_rows.push_back(item_row(OP_TICK, 4'd0, 16'd0, 12'd0));
    // Reload finished slots with equal bursts: the tie goes to slot 0.
    dir_rows.push_back(item_row(OP_LOAD, 4'd1, 16'd0, 12'd2));
    dir_rows.push_back(item_row(OP_LOAD, 4'd0, 16'd3, 12'd2));
    dir_rows.push_back(item_row(OP_TICK, 4'd0, 16'd0, 12'd0));
    dir_rows.push_back(item_row(OP_TICK, 4'd0, 16'd0, 12'd0));
    dir_rows.push_back(item_row(OP_TICK, 4'd0, 16'd0, 12'd0));
    // Reload slot 1 while it is half served.
    dir_rows.push_back(item_row(OP_LOAD, 4'd1, 16'd0, 12'd5));
    dir_rows.push_back(item_row(OP_TICK, 4'd0, 16'd0, 12'd0));
    dir_rows.push_back(cfg_row(5'd0));
    dir_rows.push_back(item_row(OP_TICK, 4'd0, 16'd0, 12'd0));
    dir_rows.push_back(item_row(OP_LOAD, 4'hF, 16'd0, 12'd1));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table.
    for (k = 0; k < dir_rows.size(); k++) begin
      row = dir_rows[k];
      if (row.is_cfg) write_active_count(row.cfg_val);
      else send_item(row.op, row.slot, row.arr, row.bur, row.known_result, row.want);
    end

    // Load every slot so that any active count scans written entries only.
    for (k = 0; k < MAX_TASKS; k++)
      send_item(OP_LOAD, SLOT_W'(k), ARR_W'(now_time) + ARR_W'($urandom_range(0, 4)),
                BUR_W'($urandom_range(1, 12)), 1'b0, '0);

    // Random workloads over a spread of active counts, the extremes included.
    // Oversized counts act as a full table. Idling varies per phase, with
    // some phases running back to back on one or both sides.
    settings   = '{5'd31, 5'd16, 5'd1, 5'($urandom_range(2, 15)),
                   5'($urandom_range(17, 30)), 5'd0, 5'd16};
    src_modes  = '{8, 0, 8, 8, 0, 8, 8};
    sink_modes = '{8, 0, 8, 0, 8, 8, 8};
    for (k = 0; k < 7; k++) begin
      write_active_count(settings[k]);
      src_gap_max  = src_modes[k];
      sink_gap_max = sink_modes[k];
      // Back-to-back sender against a long receiver hold-off: the block fills
      // up and must stall its input.
      if (k == 1) hold_request = 1'b1;
      run_workload(WORKLOAD_ITEMS);
    end

    // Finish on a full table, then on an oversized count scanning all of it.
    src_gap_max  = 8;
    sink_gap_max = 8;
    write_active_count(5'd16);
    run_workload(WORKLOAD_ITEMS);
    write_active_count(5'd31);
    run_workload(WORKLOAD_ITEMS / 3);

    drain_results();
    repeat (END_CYCLES) @(posedge clk_i);

    $display("Run covered %0d items under %0d active-count settings: %0d ticks served a task,",
             items_sent, cfg_writes, served_seen);
    $display("%0d tasks completed, clock ended at %0d, mismatches %0d.",
             completions_seen, now_time, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
